// File: design/tgl_pkg.sv
// Shared types, constants and helper functions for the tap gesture light controller.
// Used by tgl_step and tap_gesture_light_controller; depends on nothing else.
package tgl_pkg;

  // Field widths
  localparam int LevelW    = 12;
  localparam int WindowW   = 10;
  localparam int TimerW    = 11;
  localparam int ReqW      = 2;
  localparam int NewLevelW = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 12;

  localparam logic [LevelW-1:0] FullScale = 12'd4095;
  localparam logic [TimerW-1:0] TimerMax  = 11'd2047;

  // Reset values of the configuration registers
  localparam logic [WindowW-1:0] TapWindowRst    = 10'd400;
  localparam logic [LevelW-1:0]  RedStepRst      = 12'd419;
  localparam logic [LevelW-1:0]  GreenStepRst    = 12'd319;
  localparam logic [LevelW-1:0]  BlueStepRst     = 12'd219;
  localparam logic [LevelW-1:0]  RedRestartRst   = 12'd2000;
  localparam logic [LevelW-1:0]  GreenRestartRst = 12'd2500;
  localparam logic [LevelW-1:0]  BlueRestartRst  = 12'd3000;

  // Reset values of the stored levels
  localparam logic [LevelW-1:0] LevelRedRst   = 12'd0;
  localparam logic [LevelW-1:0] LevelGreenRst = 12'd3000;
  localparam logic [LevelW-1:0] LevelBlueRst  = 12'd0;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_ON   = 2'd2,
    REQ_OFF  = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAP_WINDOW    = 3'd0,
    CFG_RED_STEP      = 3'd1,
    CFG_GREEN_STEP    = 3'd2,
    CFG_BLUE_STEP     = 3'd3,
    CFG_RED_RESTART   = 3'd4,
    CFG_GREEN_RESTART = 3'd5,
    CFG_BLUE_RESTART  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [WindowW-1:0] tap_window;
    logic [LevelW-1:0]  red_step;
    logic [LevelW-1:0]  green_step;
    logic [LevelW-1:0]  blue_step;
    logic [LevelW-1:0]  red_restart;
    logic [LevelW-1:0]  green_restart;
    logic [LevelW-1:0]  blue_restart;
  } cfg_t;

  typedef struct packed {
    logic              last_pad;
    logic              tap_pending;
    logic [TimerW-1:0] since_tap;
    logic [LevelW-1:0] level_red;
    logic [LevelW-1:0] level_green;
    logic [LevelW-1:0] level_blue;
    logic              on_flag;
    logic [LevelW-1:0] drive_red;
    logic [LevelW-1:0] drive_green;
    logic [LevelW-1:0] drive_blue;
  } state_t;

  // One input word
  typedef struct packed {
    req_t                 req;
    logic                 pad;
    logic [NewLevelW-1:0] new_red;
    logic [NewLevelW-1:0] new_green;
    logic [NewLevelW-1:0] new_blue;
  } word_t;

  // Raise a nonzero level by its step; past full scale take the restart value
  function automatic logic [LevelW-1:0] brighten(input logic [LevelW-1:0] level,
                                                 input logic [LevelW-1:0] step,
                                                 input logic [LevelW-1:0] restart);
    logic [LevelW:0] sum;
    sum = {1'b0, level} + {1'b0, step};
    if (level == '0) begin
      brighten = '0;
    end else if (sum[LevelW]) begin
      brighten = restart;
    end else begin
      brighten = sum[LevelW-1:0];
    end
  endfunction

  // Saturate a requested level at full scale
  function automatic logic [LevelW-1:0] clamp_level(input logic [NewLevelW-1:0] v);
    if (v > {{(NewLevelW-LevelW){1'b0}}, FullScale}) begin
      clamp_level = FullScale;
    end else begin
      clamp_level = v[LevelW-1:0];
    end
  endfunction

endpackage

// File: design/tgl_step.sv
// Next-state logic for one word: tap timing, double-tap brighten, toggle and commands.
// Depends on tgl_pkg.
module tgl_step import tgl_pkg::*; (
  input  cfg_t   cfg,
  input  state_t cur,
  input  word_t  word,
  output state_t nxt,
  output logic   written
);

  logic              rise;
  logic [TimerW-1:0] timer;
  logic              pending;

  always_comb begin
    nxt     = cur;
    written = 1'b0;
    rise    = 1'b0;
    timer   = cur.since_tap;
    pending = cur.tap_pending;
    case (word.req)
      REQ_TICK: begin
        // timer runs only while a tap waits, saturating
        if (pending && (timer < TimerMax)) begin
          timer = timer + 1'b1;
        end
        rise = word.pad & ~cur.last_pad;
        if (rise) begin
          if (!pending) begin
            pending = 1'b1;
            timer   = '0;
          end else if (timer <= {1'b0, cfg.tap_window}) begin
            // double tap: brighten and drive stored levels
            nxt.level_red   = brighten(cur.level_red, cfg.red_step, cfg.red_restart);
            nxt.level_green = brighten(cur.level_green, cfg.green_step, cfg.green_restart);
            nxt.level_blue  = brighten(cur.level_blue, cfg.blue_step, cfg.blue_restart);
            nxt.drive_red   = nxt.level_red;
            nxt.drive_green = nxt.level_green;
            nxt.drive_blue  = nxt.level_blue;
            written         = 1'b1;
            pending         = 1'b0;
          end
        end
        // lone tap timed out: toggle the light
        if (pending && (timer >= {1'b0, cfg.tap_window})) begin
          nxt.on_flag = ~cur.on_flag;
          if (!cur.on_flag) begin
            nxt.drive_red   = nxt.level_red;
            nxt.drive_green = nxt.level_green;
            nxt.drive_blue  = nxt.level_blue;
          end else begin
            nxt.drive_red   = '0;
            nxt.drive_green = '0;
            nxt.drive_blue  = '0;
          end
          written = 1'b1;
          pending = 1'b0;
        end
        nxt.last_pad    = word.pad;
        nxt.since_tap   = timer;
        nxt.tap_pending = pending;
      end
      REQ_SET: begin
        nxt.level_red   = clamp_level(word.new_red);
        nxt.level_green = clamp_level(word.new_green);
        nxt.level_blue  = clamp_level(word.new_blue);
        nxt.drive_red   = nxt.level_red;
        nxt.drive_green = nxt.level_green;
        nxt.drive_blue  = nxt.level_blue;
        nxt.on_flag     = 1'b1;
        written         = 1'b1;
      end
      REQ_ON: begin
        nxt.drive_red   = cur.level_red;
        nxt.drive_green = cur.level_green;
        nxt.drive_blue  = cur.level_blue;
        nxt.on_flag     = 1'b1;
        written         = 1'b1;
      end
      default: begin
        // switch off
        nxt.drive_red   = '0;
        nxt.drive_green = '0;
        nxt.drive_blue  = '0;
        nxt.on_flag     = 1'b0;
        written         = 1'b1;
      end
    endcase
  end

endmodule

// File: design/tap_gesture_light_controller.sv
// Top level of the tap gesture light controller: input register, state, result register.
// Depends on tgl_pkg and tgl_step.
//
// Each accepted word (a tick with a pad sample, or a set/on/off command) yields one
// result word holding the three 12-bit DAC values, a rewrite flag and the light-on flag.
// The block sustains one word per clock while out_ready stays high: a word sits in the
// input register, where the combinational state update in tgl_step runs, and its result
// is captured in the output register once that register is free or draining. The output
// register holds a result while the consumer stalls and the input register keeps taking
// words as long as the result register can drain. Configuration
// writes take effect at the edge they occur and should be made only while idle.
module tap_gesture_light_controller import tgl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ReqW-1:0]      req_type,
  input  logic                 pad_level,
  input  logic [NewLevelW-1:0] new_red,
  input  logic [NewLevelW-1:0] new_green,
  input  logic [NewLevelW-1:0] new_blue,
  // output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LevelW-1:0]    dac_red,
  output logic [LevelW-1:0]    dac_green,
  output logic [LevelW-1:0]    dac_blue,
  output logic                 dac_written,
  output logic                 light_on
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  word_t  in_word;
  logic   in_word_valid;
  logic   written_next;
  logic   advance;

  // input register moves on when the result register is free or draining
  assign advance  = ~out_valid | out_ready;
  assign in_ready = ~in_word_valid | advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_window    <= TapWindowRst;
      cfg.red_step      <= RedStepRst;
      cfg.green_step    <= GreenStepRst;
      cfg.blue_step     <= BlueStepRst;
      cfg.red_restart   <= RedRestartRst;
      cfg.green_restart <= GreenRestartRst;
      cfg.blue_restart  <= BlueRestartRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TAP_WINDOW:    cfg.tap_window    <= cfg_data[WindowW-1:0];
        CFG_RED_STEP:      cfg.red_step      <= cfg_data[LevelW-1:0];
        CFG_GREEN_STEP:    cfg.green_step    <= cfg_data[LevelW-1:0];
        CFG_BLUE_STEP:     cfg.blue_step     <= cfg_data[LevelW-1:0];
        CFG_RED_RESTART:   cfg.red_restart   <= cfg_data[LevelW-1:0];
        CFG_GREEN_RESTART: cfg.green_restart <= cfg_data[LevelW-1:0];
        CFG_BLUE_RESTART:  cfg.blue_restart  <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word_valid <= 1'b0;
    end else if (in_ready) begin
      in_word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word.req       <= req_t'(req_type);
      in_word.pad       <= pad_level;
      in_word.new_red   <= new_red;
      in_word.new_green <= new_green;
      in_word.new_blue  <= new_blue;
    end
  end

  tgl_step u_step (
    .cfg     (cfg),
    .cur     (state),
    .word    (in_word),
    .nxt     (state_next),
    .written (written_next)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_pad    <= 1'b0;
      state.tap_pending <= 1'b0;
      state.since_tap   <= '0;
      state.level_red   <= LevelRedRst;
      state.level_green <= LevelGreenRst;
      state.level_blue  <= LevelBlueRst;
      state.on_flag     <= 1'b0;
      state.drive_red   <= '0;
      state.drive_green <= '0;
      state.drive_blue  <= '0;
    end else if (in_word_valid && advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word_valid && advance) begin
      dac_red     <= state_next.drive_red;
      dac_green   <= state_next.drive_green;
      dac_blue    <= state_next.drive_blue;
      dac_written <= written_next;
      light_on    <= state_next.on_flag;
    end
  end

endmodule
